@@ hw/rtl/chts_pkg.sv @@
// Shared types and constants for the chained hash table.
`default_nettype none
package chts_pkg;
  localparam int MaxBuckets = 16;
  localparam int PoolNodes  = 256;
  localparam int KeyBits    = 31;
  localparam int PtrBits    = 9;  // node index plus null
  localparam int IdxBits    = 8;
  localparam int BktBits    = 4;
  localparam int CntBits    = 5;
  localparam logic [CntBits-1:0] ResetBuckets = 5'd10;
  localparam logic [PtrBits-1:0] Nil = 9'd256;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_SEARCH = 2'd1,
    FN_REMOVE = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,      // rebuild free list, one node a cycle
    S_IDLE,
    S_MOD,       // one key bit of the division a cycle
    S_HEAD,      // fetch bucket head
    S_RD,        // issue node read
    S_CMP,       // compare read data
    S_LINK,      // insert: write fresh node, relink
    S_UNLINK,    // remove: relink around node
    S_FREE,      // remove: push node on free list
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;       // capture request, start the modulo
    logic mod_step;
    logic start_walk; // cur <= head
    logic rd_node;    // read key and link of cur
    logic advance;    // prev <= cur, cur <= link
    logic link_fresh; // write fresh node, point prev or head at it
    logic unlink;     // prev or head <= link of cur
    logic free_node;  // link[cur] <= free_head, free_head <= cur
    logic init_start;
    logic set_found;
    logic set_notfound;
    logic set_full;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic init_done;
    logic cur_nil;
    logic key_gt;     // key greater than node key
    logic key_eq;
    logic pool_full;
    func_t func;
  } sts_t;
endpackage
`default_nettype wire

@@ hw/rtl/chts_ctrl.sv @@
// Controller state machine for the chained hash table.
`default_nettype none
module chts_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_go,
  input  wire logic            out_take,
  input  wire chts_pkg::sts_t  sts,
  output chts_pkg::cmd_t       cmd,
  output logic                 in_rdy,
  output logic                 out_vld
);
  chts_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chts_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_rdy = 1'b0;
    out_vld = 1'b0;
    case (state_r)
      chts_pkg::S_INIT: begin
        if (sts.init_done) state_nxt = chts_pkg::S_IDLE;
      end
      chts_pkg::S_IDLE: begin
        in_rdy = 1'b1;
        if (in_go) begin
          cmd.load = 1'b1;
          state_nxt = chts_pkg::S_MOD;
        end
      end
      chts_pkg::S_MOD: begin
        cmd.mod_step = !sts.mod_done;
        if (sts.mod_done) begin
          if (sts.func == chts_pkg::FN_CLEAR) begin
            cmd.init_start = 1'b1;
            state_nxt = chts_pkg::S_OUT;
          end else if (sts.func == chts_pkg::FN_INSERT && sts.pool_full) begin
            cmd.set_full = 1'b1;
            state_nxt = chts_pkg::S_OUT;
          end else begin
            state_nxt = chts_pkg::S_HEAD;
          end
        end
      end
      chts_pkg::S_HEAD: begin
        cmd.start_walk = 1'b1;
        state_nxt = chts_pkg::S_RD;
      end
      chts_pkg::S_RD: begin
        if (sts.cur_nil) begin
          if (sts.func == chts_pkg::FN_INSERT) begin
            state_nxt = chts_pkg::S_LINK;
          end else begin
            cmd.set_notfound = 1'b1;
            state_nxt = chts_pkg::S_OUT;
          end
        end else begin
          cmd.rd_node = 1'b1;
          state_nxt = chts_pkg::S_CMP;
        end
      end
      chts_pkg::S_CMP: begin
        if (sts.func == chts_pkg::FN_INSERT) begin
          if (sts.key_gt) begin
            cmd.advance = 1'b1;
            state_nxt = chts_pkg::S_RD;
          end else begin
            state_nxt = chts_pkg::S_LINK;
          end
        end else if (!sts.key_eq) begin
          cmd.advance = 1'b1;
          state_nxt = chts_pkg::S_RD;
        end else if (sts.func == chts_pkg::FN_SEARCH) begin
          cmd.set_found = 1'b1;
          state_nxt = chts_pkg::S_OUT;
        end else begin
          state_nxt = chts_pkg::S_UNLINK;
        end
      end
      chts_pkg::S_LINK: begin
        cmd.link_fresh = 1'b1;
        state_nxt = chts_pkg::S_OUT;
      end
      chts_pkg::S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_nxt = chts_pkg::S_FREE;
      end
      chts_pkg::S_FREE: begin
        cmd.free_node = 1'b1;
        state_nxt = chts_pkg::S_OUT;
      end
      chts_pkg::S_OUT: begin
        out_vld = 1'b1;
        if (out_take) begin
          state_nxt = (sts.func == chts_pkg::FN_CLEAR) ? chts_pkg::S_INIT
                                                       : chts_pkg::S_IDLE;
        end
      end
      default: state_nxt = chts_pkg::S_INIT;
    endcase
  end
endmodule
`default_nettype wire

@@ hw/rtl/chts_dp.sv @@
// Datapath for the chained hash table: modulo unit, node memories, walk pointers.
`default_nettype none
module chts_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire chts_pkg::cmd_t                cmd,
  output chts_pkg::sts_t                     sts,
  input  wire logic [chts_pkg::CntBits-1:0]  bcount,
  input  wire logic [1:0]                    in_func,
  input  wire logic [chts_pkg::KeyBits-1:0]  in_key,
  output logic [1:0]                         res_status,
  output logic [chts_pkg::BktBits-1:0]       res_bucket,
  output logic [chts_pkg::KeyBits-1:0]       res_found
);
  localparam int KB = chts_pkg::KeyBits;
  localparam int PB = chts_pkg::PtrBits;
  localparam int IB = chts_pkg::IdxBits;
  localparam int BB = chts_pkg::BktBits;

  logic [KB-1:0] node_keys [chts_pkg::PoolNodes];
  logic [PB-1:0] node_links [chts_pkg::PoolNodes];
  logic [PB-1:0] heads_r [chts_pkg::MaxBuckets];
  logic [chts_pkg::MaxBuckets-1:0] head_vld_r;

  chts_pkg::func_t func_r;
  logic [KB-1:0] key_r, quo_r;
  logic [BB:0]   rem_r;
  logic [BB:0]   div_r;
  logic [4:0]    mcnt_r;
  logic [1:0]    status_r;
  logic [KB-1:0] found_r;
  logic [PB-1:0] cur_r, prev_r, free_r;
  logic [PB-1:0] used_r;
  logic [KB-1:0] rd_key_r;
  logic [PB-1:0] rd_link_r;
  logic [IB-1:0] icnt_r;
  logic          init_done_r;

  logic [BB:0]   div_eff;
  logic [BB+1:0] rem_sh;
  logic [BB-1:0] bkt;
  logic [PB-1:0] head_val;

  assign bkt = rem_r[BB-1:0];
  assign head_val = head_vld_r[bkt] ? heads_r[bkt] : chts_pkg::Nil;
  assign rem_sh = {rem_r, quo_r[KB-1]};

  always_comb begin
    if (bcount == '0) div_eff = (BB+1)'(1);
    else if (bcount > chts_pkg::CntBits'(chts_pkg::MaxBuckets))
      div_eff = (BB+1)'(chts_pkg::MaxBuckets);
    else div_eff = bcount;
  end

  // restoring division, one key bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= chts_pkg::func_t'(in_func);
      key_r  <= in_key;
      quo_r  <= in_key;
      rem_r  <= '0;
      div_r  <= div_eff;
      mcnt_r <= '0;
      status_r <= chts_pkg::ST_OK;
      found_r  <= '0;
    end else if (cmd.mod_step) begin
      quo_r  <= {quo_r[KB-2:0], 1'b0};
      mcnt_r <= mcnt_r + 5'd1;
      if (rem_sh >= {1'b0, div_r}) rem_r <= (BB+1)'(rem_sh - {1'b0, div_r});
      else rem_r <= rem_sh[BB:0];
    end
    if (cmd.set_full) status_r <= chts_pkg::ST_FULL;
    if (cmd.set_notfound) status_r <= chts_pkg::ST_NOTFOUND;
    if (cmd.set_found) found_r <= rd_key_r;
  end

  assign sts.mod_done  = (mcnt_r == 5'(KB));
  assign sts.init_done = init_done_r;
  assign sts.cur_nil   = cur_r[PB-1];
  assign sts.key_gt    = key_r > rd_key_r;
  assign sts.key_eq    = key_r == rd_key_r;
  assign sts.pool_full = free_r[PB-1] || used_r[PB-1];
  assign sts.func      = func_r;

  // node memories: one write port each, registered read for the walk
  logic          lk_we;
  logic [IB-1:0] lk_wa;
  logic [PB-1:0] lk_wd;
  always_comb begin
    lk_we = 1'b0;
    lk_wa = cur_r[IB-1:0];
    lk_wd = cur_r;
    if (!init_done_r) begin
      lk_we = 1'b1;
      lk_wa = icnt_r;
      lk_wd = PB'(icnt_r) + PB'(1);
    end else if (cmd.link_fresh) begin
      // fresh node points at cur
      lk_we = 1'b1;
      lk_wa = free_r[IB-1:0];
      lk_wd = cur_r;
    end else if (cmd.unlink && !prev_r[PB-1]) begin
      lk_we = 1'b1;
      lk_wa = prev_r[IB-1:0];
      lk_wd = rd_link_r;
    end else if (cmd.free_node) begin
      lk_we = 1'b1;
      lk_wa = cur_r[IB-1:0];
      lk_wd = free_r;
    end
  end

  // prev link to fresh needs a second write; take it the cycle after link
  logic fix_r;
  logic [IB-1:0] fix_a_r;
  logic [PB-1:0] fix_d_r;

  always_ff @(posedge clk) begin
    if (lk_we) node_links[lk_wa] <= lk_wd;
    else if (fix_r) node_links[fix_a_r] <= fix_d_r;
    if (cmd.link_fresh) node_keys[free_r[IB-1:0]] <= key_r;
    if (cmd.rd_node) begin
      rd_key_r  <= node_keys[cur_r[IB-1:0]];
      rd_link_r <= node_links[cur_r[IB-1:0]];
    end
    fix_a_r <= prev_r[IB-1:0];
    fix_d_r <= free_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fix_r <= 1'b0;
      init_done_r <= 1'b0;
      icnt_r <= '0;
      free_r <= '0;
      used_r <= '0;
      head_vld_r <= '0;
      cur_r <= chts_pkg::Nil;
      prev_r <= chts_pkg::Nil;
    end else begin
      fix_r <= cmd.link_fresh && !prev_r[PB-1];
      if (cmd.init_start) begin
        init_done_r <= 1'b0;
        icnt_r <= '0;
        free_r <= '0;
        used_r <= '0;
        head_vld_r <= '0;
      end else if (!init_done_r) begin
        icnt_r <= icnt_r + IB'(1);
        if (icnt_r == IB'(chts_pkg::PoolNodes-1)) init_done_r <= 1'b1;
      end
      if (cmd.start_walk) begin
        cur_r <= head_val;
        prev_r <= chts_pkg::Nil;
      end
      if (cmd.advance) begin
        prev_r <= cur_r;
        cur_r <= rd_link_r;
      end
      if (cmd.link_fresh) begin
        free_r <= node_links[free_r[IB-1:0]];
        used_r <= used_r + PB'(1);
        if (prev_r[PB-1]) begin
          heads_r[bkt] <= free_r;
          head_vld_r[bkt] <= 1'b1;
        end
      end
      if (cmd.unlink && prev_r[PB-1]) begin
        heads_r[bkt] <= rd_link_r;
        head_vld_r[bkt] <= 1'b1;
      end
      if (cmd.free_node) begin
        free_r <= cur_r;
        used_r <= used_r - PB'(1);
      end
    end
  end

  assign res_status = status_r;
  assign res_bucket = (func_r == chts_pkg::FN_CLEAR) ? '0 : bkt;
  assign res_found  = found_r;
endmodule
`default_nettype wire

@@ hw/rtl/chained_hash_table_sorted_buckets.sv @@
// Top level of the chained hash table with sorted buckets.
`default_nettype none
// Hash table with separate chaining over a 256-node pool, one request in
// work at a time. Each request (insert, search, remove, clear) is hashed
// by key modulo the configured bucket count (0 as 1, over 16 as 16) with
// a restoring divider, then walks its chain (not a clear or full insert).
// After reset and after every clear the free list is rebuilt one node a
// cycle, and no request is taken while it is rebuilt (configuration
// writes are always taken). Chains stay in ascending key order, inserts
// land before equal keys, and an insert into a full pool answers status 2.
module chained_hash_table_sorted_buckets (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data,      // bucket_count
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,      // func[1:0], key[32:2], zero fill
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata      // status[1:0], bucket_index[5:2], found_key[36:6]
);
  chts_pkg::cmd_t cmd;
  chts_pkg::sts_t sts;
  logic [chts_pkg::CntBits-1:0] bcount_r;
  logic [1:0] st;
  logic [3:0] bk;
  logic [30:0] fk;

  // hold the bucket count; a request in work keeps its own copy of the divisor
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcount_r <= chts_pkg::ResetBuckets;
    end else if (cfg_valid) begin
      bcount_r <= cfg_data;
    end
  end

  chts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_go(in_tvalid), .out_take(out_tready),
    .sts(sts), .cmd(cmd), .in_rdy(in_tready), .out_vld(out_tvalid)
  );

  chts_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .bcount(bcount_r),
    .in_func(in_tdata[1:0]), .in_key(in_tdata[32:2]),
    .res_status(st), .res_bucket(bk), .res_found(fk)
  );

  assign out_tdata = {3'b000, fk, bk, st};
endmodule
`default_nettype wire
